// File: design/clse_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and codes for the context load/store eliminator.
// No dependencies.
package clse_pkg;

	localparam int CONTEXT_BYTES    = 1024;
	localparam int VALUE_ID_BITS    = 16;
	localparam int MAX_ACCESS_BYTES = 16;

	localparam int ADDR_W = $clog2(CONTEXT_BYTES);
	localparam int SZ_W   = $clog2(MAX_ACCESS_BYTES + 1);
	localparam int OFF_W  = 10;
	localparam int TYPE_W = 4;
	localparam int VSZ_W  = 5;
	localparam int ID_W   = 16;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_STORE = 2'd2,
		CMD_OTHER = 2'd3
	} cmd_t;

	typedef struct packed {
		logic                     valid;
		logic [ADDR_W-1:0]        start;
		logic [VALUE_ID_BITS-1:0] id;
		logic [TYPE_W-1:0]        vtype;
		logic [SZ_W-1:0]          size;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CLEAR = 7'b0000010,
		S_RDA   = 7'b0000100,
		S_RDB   = 7'b0001000,
		S_EVAL  = 7'b0010000,
		S_WIPE  = 7'b0100000,
		S_FILL  = 7'b1000000
	} state_t;

endpackage

// File: design/context_load_store_eliminator.sv
`timescale 1ns / 1ps
// Context load/store eliminator: availability table in one RAM, walked one entry per cycle
// by a small sequencer. Depends on clse_pkg.
// Load/store: read the entries at both ends of the access, evaluate, then wipe and/or fill;
// load/store and out-of-range words give one result word, clear and other commands none.
// One word at a time, busy high while the table is read or walked. Reset: asynchronous,
// then clears all 1024 entries with busy high; done lasts one cycle, cannot be stalled.
module context_load_store_eliminator import clse_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        command,
	input  logic [OFF_W-1:0]  offset,
	input  logic [TYPE_W-1:0] value_type,
	input  logic [VSZ_W-1:0]  value_size,
	input  logic [ID_W-1:0]   value_id,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data,
	output logic              done,
	output logic              remove,
	output logic [ID_W-1:0]   replace_with_id,
	output logic              range_error
);

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CONTEXT_BYTES - 1);

	state_t              state_q, state_d;
	logic [ADDR_W-1:0]   ptr_q, ptr_d;
	logic [ADDR_W-1:0]   end_q, end_d;
	logic                fill_q, fill_d;
	logic                done_q, done_d;
	logic                dir_q;

	logic [1:0]               cmd_q;
	logic [ADDR_W-1:0]        off_q, last_q;
	logic [SZ_W-1:0]          sz_q;
	logic [TYPE_W-1:0]        type_q;
	logic [VALUE_ID_BITS-1:0] id_q;
	entry_t                   a_q;
	logic                     rem_q, rem_d, rerr_q, rerr_d;
	logic [ID_W-1:0]          rid_q, rid_d;

	logic [ENTRY_W-1:0] mem [CONTEXT_BYTES];
	logic [ENTRY_W-1:0] rdata_q;
	logic               we;
	logic [ADDR_W-1:0]  waddr, raddr;
	entry_t             wdata, b_e;

	logic [SZ_W-1:0]   sz_c;
	logic [OFF_W:0]    acc_end;
	logic              over;
	logic [ADDR_W-1:0] wbegin, wend;
	logic [ADDR_W:0]   wend_w;
	logic              hit_fwd, hit_bwd;

	// size clamp and range check on the incoming word
	always_comb begin
		if (value_size == '0)
			sz_c = SZ_W'(1);
		else if (int'(value_size) > MAX_ACCESS_BYTES)
			sz_c = SZ_W'(MAX_ACCESS_BYTES);
		else
			sz_c = SZ_W'(value_size);
		acc_end = {1'b0, offset} + (OFF_W + 1)'(sz_c);
		over    = int'(acc_end) > CONTEXT_BYTES;
	end

	assign b_e     = entry_t'(rdata_q);
	assign hit_fwd = a_q.valid && (a_q.start == off_q) && (a_q.vtype == type_q);
	assign hit_bwd = a_q.valid && (a_q.start == off_q) && (a_q.size >= sz_q);

	// invalidation range, widened to whole entries
	always_comb begin
		wbegin = a_q.valid ? a_q.start : off_q;
		if (b_e.valid)
			wend_w = {1'b0, b_e.start} + (ADDR_W + 1)'(b_e.size) - (ADDR_W + 1)'(1);
		else
			wend_w = {1'b0, last_q};
		if (int'(wend_w) > CONTEXT_BYTES - 1)
			wend = LAST_ADDR;
		else
			wend = wend_w[ADDR_W-1:0];
	end

	always_comb begin
		state_d = state_q;
		ptr_d   = ptr_q;
		end_d   = end_q;
		fill_d  = fill_q;
		done_d  = 1'b0;
		rem_d   = rem_q;
		rid_d   = rid_q;
		rerr_d  = rerr_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (command)
						CMD_CLEAR: begin
							state_d = S_CLEAR;
							ptr_d   = '0;
						end
						CMD_LOAD, CMD_STORE: begin
							if (over) begin
								done_d = 1'b1;
								rem_d  = 1'b0;
								rid_d  = '0;
								rerr_d = 1'b1;
							end else begin
								state_d = S_RDA;
							end
						end
						default: ;
					endcase
				end
			end
			S_CLEAR: begin
				ptr_d = ptr_q + ADDR_W'(1);
				if (ptr_q == LAST_ADDR)
					state_d = S_IDLE;
			end
			S_RDA: state_d = S_RDB;
			S_RDB: state_d = S_EVAL;
			S_EVAL: begin
				rem_d  = 1'b0;
				rid_d  = '0;
				rerr_d = 1'b0;
				if (!dir_q && cmd_q == CMD_LOAD && hit_fwd) begin
					done_d  = 1'b1;
					rem_d   = 1'b1;
					rid_d   = ID_W'(a_q.id);
					state_d = S_IDLE;
				end else if (dir_q && cmd_q == CMD_STORE && hit_bwd) begin
					done_d  = 1'b1;
					rem_d   = 1'b1;
					state_d = S_IDLE;
				end else begin
					fill_d = !(dir_q && cmd_q == CMD_LOAD);
					end_d  = wend;
					ptr_d  = wbegin;
					if (wbegin <= wend) begin
						state_d = S_WIPE;
					end else if (!(dir_q && cmd_q == CMD_LOAD)) begin
						state_d = S_FILL;
						ptr_d   = off_q;
					end else begin
						done_d  = 1'b1;
						state_d = S_IDLE;
					end
				end
			end
			S_WIPE: begin
				ptr_d = ptr_q + ADDR_W'(1);
				if (ptr_q == end_q) begin
					if (fill_q) begin
						state_d = S_FILL;
						ptr_d   = off_q;
					end else begin
						done_d  = 1'b1;
						state_d = S_IDLE;
					end
				end
			end
			S_FILL: begin
				ptr_d = ptr_q + ADDR_W'(1);
				if (ptr_q == last_q) begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ptr_q   <= '0;
			end_q   <= '0;
			fill_q  <= 1'b0;
			done_q  <= 1'b0;
			dir_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			ptr_q   <= ptr_d;
			end_q   <= end_d;
			fill_q  <= fill_d;
			done_q  <= done_d;
			if (cfg_valid && cfg_ready)
				dir_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			cmd_q  <= command;
			off_q  <= ADDR_W'(offset);
			last_q <= ADDR_W'(acc_end - (OFF_W + 1)'(1));
			sz_q   <= sz_c;
			type_q <= value_type;
			id_q   <= VALUE_ID_BITS'(value_id);
		end
		if (state_q == S_RDB)
			a_q <= entry_t'(rdata_q);
		rem_q  <= rem_d;
		rid_q  <= rid_d;
		rerr_q <= rerr_d;
	end

	// table RAM
	always_comb begin
		we          = (state_q == S_CLEAR) || (state_q == S_WIPE) || (state_q == S_FILL);
		waddr       = ptr_q;
		raddr       = (state_q == S_RDA) ? off_q : last_q;
		wdata       = '0;
		if (state_q == S_FILL) begin
			wdata.valid = 1'b1;
			wdata.start = off_q;
			wdata.id    = id_q;
			wdata.vtype = type_q;
			wdata.size  = sz_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= ENTRY_W'(wdata);
		rdata_q <= mem[raddr];
	end

	assign busy            = (state_q != S_IDLE);
	assign cfg_ready       = 1'b1;
	assign done            = done_q;
	assign remove          = rem_q;
	assign replace_with_id = rid_q;
	assign range_error     = rerr_q;

endmodule

// File: design/clse_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the context load/store eliminator, bound to the top level.
// Depends on clse_pkg and context_load_store_eliminator.
module clse_checker import clse_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input logic [1:0]      command,
	input logic            done,
	input logic            remove,
	input logic [ID_W-1:0] replace_with_id,
	input logic            range_error
);

	a_rerr_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		done && range_error |-> !remove)
		else $error("range error word marked for removal");

	a_kept_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		done && !remove |-> replace_with_id == '0)
		else $error("kept word carries a replacement id");

	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command == CMD_CLEAR |=> busy)
		else $error("clear did not start a table sweep");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !start |=> !done)
		else $error("result word without pending work");

endmodule

bind context_load_store_eliminator clse_checker u_clse_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.command         (command),
	.done            (done),
	.remove          (remove),
	.replace_with_id (replace_with_id),
	.range_error     (range_error)
);

// File: tb/tb_context_load_store_eliminator.sv
`timescale 1ns / 1ps
// Self-checking bench for context_load_store_eliminator: directed and random instruction
// streams in both directions, checked against a behavioural copy of the availability table.
// Depends on clse_pkg and the context_load_store_eliminator RTL.
module tb_context_load_store_eliminator;
	import clse_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int PHASE_WORDS = 300;

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] base;
		logic [ID_W-1:0]   id;
		logic [TYPE_W-1:0] vtype;
		logic [VSZ_W-1:0]  len;
	} slot_s;

	typedef struct packed {
		logic            remove;
		logic [ID_W-1:0] id;
		logic            range_error;
	} verdict_s;

	class verdict_board;
		slot_s    avail [CONTEXT_BYTES];
		verdict_s verdicts_due [$];
		bit       backward;
		int       errors;

		function new();
			errors = 0;
			backward = 0;
			wipe_all();
		endfunction

		function void wipe_all();
			foreach (avail[i]) avail[i] = '0;
		endfunction

		// invalidate a range, widened to the whole values found at both ends
		function void drop(int off, int len);
			int lo;
			int hi;
			lo = off;
			hi = off + len - 1;
			if (avail[off].valid)
				lo = int'(avail[off].base);
			if (avail[off + len - 1].valid)
				hi = int'(avail[off + len - 1].base) + int'(avail[off + len - 1].len) - 1;
			if (hi >= CONTEXT_BYTES)
				hi = CONTEXT_BYTES - 1;
			for (int i = lo; i <= hi; i++)
				avail[i] = '0;
		endfunction

		function void claim(int off, int len, logic [ID_W-1:0] vid, logic [TYPE_W-1:0] vt);
			slot_s s;
			drop(off, len);
			s.valid = 1'b1;
			s.base  = off[ADDR_W-1:0];
			s.id    = vid;
			s.vtype = vt;
			s.len   = len[VSZ_W-1:0];
			for (int i = off; i < off + len; i++)
				avail[i] = s;
		endfunction

		function void note_word(cmd_t cmd, logic [OFF_W-1:0] off, logic [TYPE_W-1:0] vt,
				logic [VSZ_W-1:0] vs, logic [ID_W-1:0] vid);
			int       len;
			int       a;
			verdict_s v;
			slot_s    head;
			if (cmd == CMD_CLEAR) begin
				wipe_all();
				return;
			end
			if (cmd == CMD_OTHER)
				return;
			len = (vs == 0) ? 1 : (vs > MAX_ACCESS_BYTES) ? MAX_ACCESS_BYTES : int'(vs);
			a = int'(off);
			v = '0;
			head = avail[a];
			if (a + len > CONTEXT_BYTES) begin
				v.range_error = 1'b1;
			end else if (!backward) begin
				if (cmd == CMD_LOAD && head.valid && head.base == off && head.vtype == vt) begin
					v.remove = 1'b1;
					v.id = head.id;
				end else begin
					claim(a, len, vid, vt);
				end
			end else if (cmd == CMD_LOAD) begin
				drop(a, len);
			end else if (head.valid && head.base == off && int'(head.len) >= len) begin
				v.remove = 1'b1;
			end else begin
				claim(a, len, vid, vt);
			end
			verdicts_due.push_back(v);
		endfunction

		function void check_verdict(logic rm, logic [ID_W-1:0] rid, logic re);
			verdict_s v;
			if (verdicts_due.size() == 0) begin
				$error("unexpected result word: remove %0d id %0h range_error %0d", rm, rid, re);
				errors++;
				return;
			end
			v = verdicts_due.pop_front();
			if (rm !== v.remove) begin
				$error("remove: expected %0d, got %0d", v.remove, rm);
				errors++;
			end
			if (rid !== v.id) begin
				$error("replace_with_id: expected %0h, got %0h", v.id, rid);
				errors++;
			end
			if (re !== v.range_error) begin
				$error("range_error: expected %0d, got %0d", v.range_error, re);
				errors++;
			end
		endfunction

		function int pending();
			return verdicts_due.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        command;
	logic [OFF_W-1:0]  offset;
	logic [TYPE_W-1:0] value_type;
	logic [VSZ_W-1:0]  value_size;
	logic [ID_W-1:0]   value_id;
	logic              cfg_valid;
	logic              cfg_ready;
	logic              cfg_data;
	logic              done;
	logic              remove;
	logic [ID_W-1:0]   replace_with_id;
	logic              range_error;

	verdict_board board = new();
	int quiet;

	context_load_store_eliminator dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.command        (command),
		.offset         (offset),
		.value_type     (value_type),
		.value_size     (value_size),
		.value_id       (value_id),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.done           (done),
		.remove         (remove),
		.replace_with_id(replace_with_id),
		.range_error    (range_error)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			board.check_verdict(remove, replace_with_id, range_error);
	end

	always @(posedge clk) begin
		if ((start && busy === 1'b0) || done === 1'b1 || (cfg_valid && cfg_ready === 1'b1))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_word(input cmd_t c, input logic [OFF_W-1:0] off,
			input logic [TYPE_W-1:0] vt, input logic [VSZ_W-1:0] vs, input logic [ID_W-1:0] vid);
		@(negedge clk);
		start      = 1'b1;
		command    = c;
		offset     = off;
		value_type = vt;
		value_size = vs;
		value_id   = vid;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		board.note_word(c, off, vt, vs, vid);
	endtask

	task automatic hold_off(input int n);
		@(negedge clk);
		start = 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// no new word until every verdict is back and the table walk has finished
	task automatic drain_all();
		@(negedge clk);
		start = 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
	endtask

	task automatic write_direction(input logic d);
		drain_all();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = d;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		board.backward = d;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic random_phase(input int words, input bit pause_midway);
		cmd_t              c;
		logic [OFF_W-1:0]  off;
		logic [TYPE_W-1:0] vt;
		logic [VSZ_W-1:0]  vs;
		logic [OFF_W-1:0]  last_off;
		logic [TYPE_W-1:0] last_vt;
		int                win;
		int                burst;
		int                r;
		win = $urandom_range(CONTEXT_BYTES - 48);
		burst = 0;
		last_off = OFF_W'(win);
		last_vt = '0;
		for (int n = 0; n < words; n++) begin
			if (pause_midway && n == words / 2)
				drain_all();
			if (burst == 0) begin
				if ($urandom_range(3) != 0)
					hold_off($urandom_range(1, 8));
				burst = $urandom_range(1, 24);
			end
			burst--;
			r = $urandom_range(99);
			c = (r < 2) ? CMD_CLEAR : (r < 6) ? CMD_OTHER : (r < 52) ? CMD_LOAD : CMD_STORE;
			r = $urandom_range(99);
			if (r < 30) begin
				off = last_off;
				vt = ($urandom_range(9) < 7) ? last_vt : 4'($urandom_range(1));
			end else begin
				if (r < 75)
					off = OFF_W'(win + int'($urandom_range(47)));
				else if (r < 85)
					off = OFF_W'($urandom_range(CONTEXT_BYTES - 16, CONTEXT_BYTES - 1));
				else
					off = OFF_W'($urandom_range(CONTEXT_BYTES - 1));
				vt = ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1));
			end
			if ($urandom_range(99) < 85)
				vs = 5'(1 << $urandom_range(4));
			else
				vs = VSZ_W'($urandom_range(31));
			send_word(c, off, vt, vs, ID_W'($urandom_range(65535)));
			last_off = off;
			last_vt = vt;
		end
	endtask

	initial begin
		clk        = 1'b0;
		arst_n     = 1'b0;
		start      = 1'b0;
		command    = CMD_OTHER;
		offset     = '0;
		value_type = '0;
		value_size = '0;
		value_id   = '0;
		cfg_valid  = 1'b0;
		cfg_data   = 1'b0;
		quiet      = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// forward: hits, type and start mismatches, top edge, size clamping
		send_word(CMD_STORE, 10'd0,    4'd3,  5'd4,  16'hAAAA);
		send_word(CMD_LOAD,  10'd0,    4'd3,  5'd4,  16'h0001);
		send_word(CMD_LOAD,  10'd0,    4'd5,  5'd4,  16'h0002);
		send_word(CMD_LOAD,  10'd2,    4'd5,  5'd2,  16'h0003);
		send_word(CMD_LOAD,  10'd0,    4'd5,  5'd4,  16'h0004);
		send_word(CMD_STORE, 10'd1008, 4'd15, 5'd16, 16'hFFFF);
		send_word(CMD_LOAD,  10'd1009, 4'd15, 5'd16, 16'h0005);
		send_word(CMD_LOAD,  10'd1023, 4'd15, 5'd1,  16'h0006);
		send_word(CMD_LOAD,  10'd1008, 4'd15, 5'd16, 16'h0007);
		send_word(CMD_STORE, 10'd100,  4'd1,  5'd0,  16'h1234);
		send_word(CMD_LOAD,  10'd100,  4'd1,  5'd0,  16'h0008);
		send_word(CMD_STORE, 10'd200,  4'd2,  5'd31, 16'h5678);
		send_word(CMD_STORE, 10'd1023, 4'd0,  5'd2,  16'h0009);
		send_word(CMD_OTHER, 10'd1023, 4'd15, 5'd31, 16'hFFFF);
		send_word(CMD_CLEAR, 10'd0,    4'd0,  5'd0,  16'h0000);
		send_word(CMD_LOAD,  10'd200,  4'd2,  5'd16, 16'h000A);
		send_word(CMD_LOAD,  10'd200,  4'd2,  5'd16, 16'h000B);

		// backward: dead stores, size ordering, load invalidation
		write_direction(1'b1);
		send_word(CMD_STORE, 10'd50,   4'd0,  5'd8,  16'h0100);
		send_word(CMD_STORE, 10'd50,   4'd0,  5'd4,  16'h0101);
		send_word(CMD_STORE, 10'd50,   4'd0,  5'd16, 16'h0102);
		send_word(CMD_LOAD,  10'd60,   4'd0,  5'd4,  16'h0103);
		send_word(CMD_STORE, 10'd50,   4'd0,  5'd4,  16'h0104);
		send_word(CMD_LOAD,  10'd1020, 4'd0,  5'd8,  16'h0105);
		send_word(CMD_CLEAR, 10'd0,    4'd0,  5'd0,  16'h0000);
		send_word(CMD_STORE, 10'd50,   4'd0,  5'd1,  16'h0106);

		for (int p = 0; p < 6; p++) begin
			write_direction(p[0]);
			random_phase(PHASE_WORDS, p == 2);
		end

		drain_all();
		repeat (100) @(posedge clk);
		while (board.pending() != 0) begin
			$error("verdict never arrived");
			board.errors++;
			void'(board.verdicts_due.pop_front());
		end
		if (board.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
